// ===== rtl/ecsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ecsm_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned SegW   = 7;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [SegW-1:0]   seg_t;
  typedef logic [1:0]        req_t;
  typedef logic [1:0]        digit_idx_t;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_PRESS = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CFG_MAX_VALUE       = 2'd0,
    CFG_COUNTDOWN_START = 2'd1,
    CFG_TICKS_PER_STEP  = 2'd2,
    CFG_DEBOUNCE_MS     = 2'd3
  } cfg_idx_e;

  localparam value_t      MaxValueRst       = 12'd4095;
  localparam logic [3:0]  CountdownStartRst = 4'd10;
  localparam logic [15:0] TicksPerStepRst   = 16'd200;
  localparam logic [15:0] DebounceMsRst     = 16'd200;
  localparam logic [4:0]  CountdownValRst   = 5'd10;

  localparam seg_t SegDark = 7'h7F;

  // floor(v / 10^n) for v < 4096 by reciprocal multiplication
  localparam logic [15:0] RecipOne      = 16'd1;
  localparam logic [15:0] RecipTen      = 16'd6554;
  localparam logic [15:0] RecipHundred  = 16'd41944;
  localparam logic [15:0] RecipThousand = 16'd4195;

  typedef struct packed {
    logic       digit_valid;
    digit_idx_t digit_index;
    value_t     shown_value;
    logic       counting_down;
    logic       press_accepted;
  } beat_t;

  function automatic seg_t seg_of(input logic [3:0] d);
    seg_t s;
    case (d)
      4'd0: s = 7'h40;
      4'd1: s = 7'h79;
      4'd2: s = 7'h24;
      4'd3: s = 7'h30;
      4'd4: s = 7'h19;
      4'd5: s = 7'h12;
      4'd6: s = 7'h02;
      4'd7: s = 7'h78;
      4'd8: s = 7'h00;
      4'd9: s = 7'h10;
      default: s = SegDark;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ecsm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ecsm_in_if;
  import ecsm_pkg::*;

  logic        valid;
  logic        ready;
  req_t        req_type;
  logic        direction;
  logic [31:0] now_ms;

  modport source (output valid, req_type, direction, now_ms, input ready);
  modport sink   (input valid, req_type, direction, now_ms, output ready);
endinterface

interface ecsm_out_if;
  import ecsm_pkg::*;

  logic       valid;
  logic       ready;
  logic       digit_valid;
  digit_idx_t digit_index;
  seg_t       segments_n;
  value_t     shown_value;
  logic       counting_down;
  logic       press_accepted;

  modport source (output valid, digit_valid, digit_index, segments_n, shown_value,
                  counting_down, press_accepted, input ready);
  modport sink   (input valid, digit_valid, digit_index, segments_n, shown_value,
                  counting_down, press_accepted, output ready);
endinterface

`default_nettype wire

// ===== rtl/encoder_counter_seven_segment_mux_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields
// in_i     in   req_type[1:0], direction, now_ms[31:0]
// out_o    out  digit_valid, digit_index[1:0], segments_n[6:0], shown_value[11:0],
//               counting_down, press_accepted
// cfg      in   cfg_we_i, cfg_index_i[1:0], cfg_data_i[15:0]
//
// One beat accepted per cycle while in_i.ready is high; results leave from s3_q.
// State updates at the accept edge; two further stages split out the decimal digit
// (one reciprocal multiply, then a mod-ten stage with the segment decode).
// Reset clears state, config and valid flags; pipeline data registers are not reset.
// A stalled output holds; each stage refills as soon as the one after it moves.
module encoder_counter_seven_segment_mux_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  ecsm_pkg::cfg_idx_e   cfg_index_i,
  input  wire [15:0]           cfg_data_i,
  ecsm_in_if.sink              in_i,
  ecsm_out_if.source           out_o
);
  import ecsm_pkg::*;

  value_t      max_value_q;
  logic [3:0]  cd_start_q;
  logic [15:0] ticks_per_step_q;
  logic [15:0] debounce_ms_q;

  logic        mode_q, mode_d;
  logic [4:0]  cd_val_q, cd_val_d;
  logic [15:0] tick_q, tick_d;
  value_t      enc_q, enc_d;
  value_t      latched_q, latched_d;
  digit_idx_t  ptr_q, ptr_d;
  logic [31:0] last_press_q, last_press_d;

  logic        v1_q, v2_q, v3_q;
  logic        rdy1, rdy2, rdy3;
  logic        accept;
  beat_t       s1_d, s1_q, s2_q, s3_q;
  value_t      q2_q;
  seg_t        seg3_q;

  logic [15:0] tick_inc;
  logic [31:0] press_gap;
  logic        press_ok;

  logic [15:0] recip;
  logic [27:0] prod2;
  value_t      q2_d;
  logic [24:0] prod3;
  logic [8:0]  quot3;
  value_t      rem3;

  assign rdy3     = !v3_q || out_o.ready;
  assign rdy2     = !v2_q || rdy3;
  assign rdy1     = !v1_q || rdy2;
  assign in_i.ready = rdy1;
  assign accept   = in_i.valid && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q      <= MaxValueRst;
      cd_start_q       <= CountdownStartRst;
      ticks_per_step_q <= TicksPerStepRst;
      debounce_ms_q    <= DebounceMsRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_VALUE:       max_value_q      <= cfg_data_i[ValueW-1:0];
        CFG_COUNTDOWN_START: cd_start_q       <= cfg_data_i[3:0];
        CFG_TICKS_PER_STEP:  ticks_per_step_q <= cfg_data_i;
        CFG_DEBOUNCE_MS:     debounce_ms_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tick_inc  = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
  assign press_gap = in_i.now_ms - last_press_q;
  assign press_ok  = press_gap > {16'd0, debounce_ms_q};

  always_comb begin
    mode_d       = mode_q;
    cd_val_d     = cd_val_q;
    tick_d       = tick_q;
    enc_d        = enc_q;
    latched_d    = latched_q;
    ptr_d        = ptr_q;
    last_press_d = last_press_q;
    s1_d         = '0;
    if (accept) begin
      case (in_i.req_type)
        REQ_TICK: begin
          if (mode_q) begin
            if (tick_inc >= ticks_per_step_q) begin
              tick_d = '0;
              if (cd_val_q == '0) begin
                mode_d    = 1'b0;
                enc_d     = '0;
                latched_d = '0;
              end else begin
                cd_val_d  = cd_val_q - 5'd1;
                latched_d = {7'd0, cd_val_q - 5'd1};
              end
            end else begin
              tick_d = tick_inc;
            end
          end
          ptr_d              = ptr_q + 2'd1;
          s1_d.digit_valid   = 1'b1;
          s1_d.digit_index   = ptr_q;
        end
        REQ_STEP: begin
          if (!mode_q) begin
            if (in_i.direction) begin
              enc_d = (enc_q >= max_value_q) ? '0 : enc_q + 12'd1;
            end else begin
              enc_d = (enc_q == '0) ? max_value_q : enc_q - 12'd1;
            end
            latched_d = enc_d;
          end
        end
        REQ_PRESS: begin
          if (press_ok) begin
            s1_d.press_accepted = 1'b1;
            last_press_d        = in_i.now_ms;
            if (!mode_q) begin
              mode_d    = 1'b1;
              cd_val_d  = {1'b0, cd_start_q};
              tick_d    = '0;
              latched_d = {8'd0, cd_start_q};
            end
          end
        end
        default: ;
      endcase
    end
    s1_d.shown_value   = latched_d;
    s1_d.counting_down = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      cd_val_q     <= CountdownValRst;
      tick_q       <= '0;
      enc_q        <= '0;
      latched_q    <= '0;
      ptr_q        <= '0;
      last_press_q <= '0;
    end else begin
      mode_q       <= mode_d;
      cd_val_q     <= cd_val_d;
      tick_q       <= tick_d;
      enc_q        <= enc_d;
      latched_q    <= latched_d;
      ptr_q        <= ptr_d;
      last_press_q <= last_press_d;
    end
  end

  // stage 2: shift the wanted decimal place down to the units
  always_comb begin
    case (s1_q.digit_index)
      2'd0:    recip = RecipOne;
      2'd1:    recip = RecipTen;
      2'd2:    recip = RecipHundred;
      default: recip = RecipThousand;
    endcase
    prod2 = s1_q.shown_value * recip;
    case (s1_q.digit_index)
      2'd0:    q2_d = s1_q.shown_value;
      2'd1:    q2_d = prod2[27:16];
      default: q2_d = {6'd0, prod2[27:22]};
    endcase
  end

  // stage 3: units digit of the quotient
  assign prod3 = q2_q * 13'd6554;
  assign quot3 = prod3[24:16];
  assign rem3  = q2_q - ({3'd0, quot3} * 12'd10);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= accept;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) begin
      s2_q <= s1_q;
      q2_q <= q2_d;
    end
    if (rdy3) begin
      s3_q   <= s2_q;
      seg3_q <= s2_q.digit_valid ? seg_of(rem3[3:0]) : SegDark;
    end
  end

  assign out_o.valid          = v3_q;
  assign out_o.digit_valid    = s3_q.digit_valid;
  assign out_o.digit_index    = s3_q.digit_index;
  assign out_o.segments_n     = seg3_q;
  assign out_o.shown_value    = s3_q.shown_value;
  assign out_o.counting_down  = s3_q.counting_down;
  assign out_o.press_accepted = s3_q.press_accepted;

  a_cd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_val_q <= 5'd15)
    else $error("countdown value out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with a free stage");

  a_ptr_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.req_type == REQ_TICK) |=> ptr_q == 2'($past(ptr_q) + 2'd1))
    else $error("digit pointer did not advance on a tick");

  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.digit_valid) |->
      (out_o.segments_n == SegDark && out_o.digit_index == 2'd0))
    else $error("non-digit beat drives segments");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ecsm_pkg::*;

  localparam req_t        ReqSpare      = 2'd3;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned ItemsPerPhase = 135;
  localparam int unsigned MaxReports    = 10;

  typedef struct packed {
    logic       digit_valid;
    digit_idx_t digit_index;
    seg_t       segments_n;
    value_t     shown_value;
    logic       counting_down;
    logic       press_accepted;
  } disp_beat_t;

  typedef struct {
    req_t        req;
    logic        dir;
    logic [31:0] now;
    logic        typed;
    disp_beat_t  res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [15:0] cfg_data;
  logic [9:0]  stall_cyc = '0;

  ecsm_in_if  in_bus ();
  ecsm_out_if out_bus ();

  encoder_counter_seven_segment_mux_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state and register copy
  value_t      max_val    = MaxValueRst;
  logic [3:0]  cd_start   = CountdownStartRst;
  logic [15:0] tick_limit = TicksPerStepRst;
  logic [15:0] debounce   = DebounceMsRst;

  logic        cd_mode    = 1'b0;
  logic [4:0]  cd_val     = CountdownValRst;
  logic [15:0] tick_acc   = '0;
  value_t      enc_cnt    = '0;
  value_t      latched    = '0;
  digit_idx_t  digit_ptr  = '0;
  logic [31:0] last_press = '0;

  disp_beat_t  display_q[$];
  dir_row_t    rows[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned gap_len    = 0;

  function automatic int unsigned dec_digit(value_t v, digit_idx_t pos);
    int unsigned x;
    x = v;
    case (pos)
      2'd0: return x % 10;
      2'd1: return (x / 10) % 10;
      2'd2: return (x / 100) % 10;
      default: return x / 1000;
    endcase
  endfunction

  function automatic seg_t seg_pattern(int unsigned d);
    case (d)
      0: return 7'h40;
      1: return 7'h79;
      2: return 7'h24;
      3: return 7'h30;
      4: return 7'h19;
      5: return 7'h12;
      6: return 7'h02;
      7: return 7'h78;
      8: return 7'h00;
      9: return 7'h10;
      default: return 7'h7F;
    endcase
  endfunction

  function automatic disp_beat_t predict_display(req_t req, logic dir, logic [31:0] now);
    disp_beat_t b;
    b = '{digit_valid: 1'b0, digit_index: 2'd0, segments_n: SegDark,
          shown_value: '0, counting_down: 1'b0, press_accepted: 1'b0};
    case (req)
      REQ_TICK: begin
        if (cd_mode) begin
          if (tick_acc != 16'hFFFF) tick_acc = tick_acc + 16'd1;
          if (tick_acc >= tick_limit) begin
            tick_acc = '0;
            if (cd_val == 5'd0) begin
              cd_mode = 1'b0;
              enc_cnt = '0;
              latched = '0;
            end else begin
              cd_val  = cd_val - 5'd1;
              latched = value_t'(cd_val);
            end
          end
        end
        b.digit_valid = 1'b1;
        b.digit_index = digit_ptr;
        b.segments_n  = seg_pattern(dec_digit(latched, digit_ptr));
        digit_ptr     = digit_ptr + 2'd1;
      end
      REQ_STEP: begin
        if (!cd_mode) begin
          if (dir) enc_cnt = (enc_cnt >= max_val) ? '0 : enc_cnt + 12'd1;
          else     enc_cnt = (enc_cnt == '0) ? max_val : enc_cnt - 12'd1;
          latched = enc_cnt;
        end
      end
      REQ_PRESS: begin
        if ((now - last_press) > {16'd0, debounce}) begin
          b.press_accepted = 1'b1;
          last_press       = now;
          if (!cd_mode) begin
            cd_mode  = 1'b1;
            cd_val   = {1'b0, cd_start};
            tick_acc = '0;
            latched  = value_t'(cd_val);
          end
        end
      end
      default: ;
    endcase
    b.shown_value   = latched;
    b.counting_down = cd_mode;
    return b;
  endfunction

  task automatic add_row(req_t req, logic dir, logic [31:0] now, logic typed,
                         disp_beat_t res);
    rows.push_back('{req: req, dir: dir, now: now, typed: typed, res: res});
  endtask

  task automatic send_beat(req_t req, logic dir, logic [31:0] now, logic typed,
                           disp_beat_t res, logic is_last);
    disp_beat_t pred;
    in_bus.valid     <= 1'b1;
    in_bus.req_type  <= req;
    in_bus.direction <= dir;
    in_bus.now_ms    <= now;
    do @(posedge clk_i); while (!in_bus.ready);
    pred = predict_display(req, dir, now);
    display_q.push_back(typed ? res : pred);
    if (burst_left > 0) begin
      burst_left--;
      gap_len = 0;
    end else begin
      burst_left = $urandom_range(1, 30);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    if (gap_len > 0 || is_last) in_bus.valid <= 1'b0;
    repeat (gap_len) @(posedge clk_i);
  endtask

  task automatic drain_display;
    while (display_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_regs(value_t mv, logic [3:0] cs, logic [15:0] tps, logic [15:0] db);
    logic [15:0] vals[4];
    vals[0] = {4'd0, mv};
    vals[1] = {12'd0, cs};
    vals[2] = tps;
    vals[3] = db;
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_idx_e'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
      case (cfg_idx_e'(i))
        CFG_MAX_VALUE:       max_val    = vals[i][11:0];
        CFG_COUNTDOWN_START: cd_start   = vals[i][3:0];
        CFG_TICKS_PER_STEP:  tick_limit = vals[i];
        CFG_DEBOUNCE_MS:     debounce   = vals[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 10'd1;
    case (stall_cyc[9:8])
      2'd0: out_bus.ready <= 1'b1;
      2'd1: out_bus.ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_bus.ready <= (stall_cyc[3:0] < 4'd10);
      default: out_bus.ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk_i) begin
    disp_beat_t got, want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = '{digit_valid: out_bus.digit_valid, digit_index: out_bus.digit_index,
              segments_n: out_bus.segments_n, shown_value: out_bus.shown_value,
              counting_down: out_bus.counting_down, press_accepted: out_bus.press_accepted};
      if (display_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected beat: dv=%0d idx=%0d seg=%02h val=%0d cd=%0d pa=%0d",
                   got.digit_valid, got.digit_index, got.segments_n, got.shown_value,
                   got.counting_down, got.press_accepted);
      end else begin
        want = display_q.pop_front();
        if (got.digit_valid   !== want.digit_valid   ||
            got.digit_index   !== want.digit_index   ||
            got.segments_n    !== want.segments_n    ||
            got.shown_value   !== want.shown_value   ||
            got.counting_down !== want.counting_down ||
            got.press_accepted !== want.press_accepted) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display({"beat mismatch: exp dv=%0d idx=%0d seg=%02h val=%0d cd=%0d pa=%0d",
                      " | got dv=%0d idx=%0d seg=%02h val=%0d cd=%0d pa=%0d"},
                     want.digit_valid, want.digit_index, want.segments_n,
                     want.shown_value, want.counting_down, want.press_accepted,
                     got.digit_valid, got.digit_index, got.segments_n,
                     got.shown_value, got.counting_down, got.press_accepted);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    value_t      mv;
    logic [3:0]  cs;
    logic [15:0] tps;
    logic [15:0] db;
    logic [31:0] wall_ms;
    logic [31:0] now;
    req_t        req;
    logic        dir;
    int unsigned pick;

    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_MAX_VALUE;
    cfg_data         <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.req_type  <= REQ_TICK;
    in_bus.direction <= 1'b0;
    in_bus.now_ms    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(REQ_TICK,  1'b0, 32'd0,   1'b1, {1'b1, 2'd0, 7'h40, 12'd0,    1'b0, 1'b0});
    add_row(REQ_STEP,  1'b0, 32'd0,   1'b1, {1'b0, 2'd0, 7'h7F, 12'd4095, 1'b0, 1'b0});
    add_row(REQ_TICK,  1'b1, 32'd7,   1'b1, {1'b1, 2'd1, 7'h10, 12'd4095, 1'b0, 1'b0});
    add_row(REQ_TICK,  1'b0, 32'd0,   1'b1, {1'b1, 2'd2, 7'h40, 12'd4095, 1'b0, 1'b0});
    add_row(REQ_TICK,  1'b0, 32'd0,   1'b1, {1'b1, 2'd3, 7'h19, 12'd4095, 1'b0, 1'b0});
    add_row(REQ_STEP,  1'b1, 32'd0,   1'b1, {1'b0, 2'd0, 7'h7F, 12'd0,    1'b0, 1'b0});
    add_row(REQ_STEP,  1'b1, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(ReqSpare,  1'b1, 32'd0,   1'b1, {1'b0, 2'd0, 7'h7F, 12'd1,    1'b0, 1'b0});
    add_row(REQ_PRESS, 1'b0, 32'd200, 1'b1, {1'b0, 2'd0, 7'h7F, 12'd1,    1'b0, 1'b0});
    add_row(REQ_PRESS, 1'b0, 32'd201, 1'b1, {1'b0, 2'd0, 7'h7F, 12'd10,   1'b1, 1'b1});
    add_row(REQ_STEP,  1'b1, 32'd0,   1'b1, {1'b0, 2'd0, 7'h7F, 12'd10,   1'b1, 1'b0});
    add_row(REQ_PRESS, 1'b1, 32'd300, 1'b1, {1'b0, 2'd0, 7'h7F, 12'd10,   1'b1, 1'b0});
    add_row(REQ_PRESS, 1'b0, 32'd402, 1'b1, {1'b0, 2'd0, 7'h7F, 12'd10,   1'b1, 1'b1});
    add_row(REQ_TICK,  1'b0, 32'd0,   1'b1, {1'b1, 2'd0, 7'h40, 12'd10,   1'b1, 1'b0});
    add_row(REQ_PRESS, 1'b1, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(REQ_PRESS, 1'b0, 32'h0000_0050, 1'b0, '0);
    add_row(REQ_TICK,  1'b1, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(REQ_STEP,  1'b0, 32'hAAAA_5555, 1'b0, '0);
    add_row(ReqSpare,  1'b0, 32'h5555_AAAA, 1'b0, '0);

    foreach (rows[i])
      send_beat(rows[i].req, rows[i].dir, rows[i].now, rows[i].typed, rows[i].res,
                i == rows.size() - 1);

    wall_ms = 32'd1000;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain_display();
      case (ph)
        0: begin mv = 12'd4095; cs = 4'd15; tps = 16'd1;     db = 16'd0;     end
        1: begin mv = 12'd1;    cs = 4'd0;  tps = 16'd0;     db = 16'd65535; end
        2: begin mv = 12'd9;    cs = 4'd3;  tps = 16'd2;     db = 16'd10;    end
        3: begin mv = 12'd4095; cs = 4'd15; tps = 16'd65535; db = 16'd200;   end
        4: begin mv = 12'd999;  cs = 4'd5;  tps = 16'd3;     db = 16'd1;     end
        default: begin
          mv  = 12'($urandom_range(1, 4095));
          cs  = 4'($urandom_range(0, 15));
          tps = 16'($urandom_range(1, 6));
          db  = 16'($urandom_range(0, 300));
        end
      endcase
      write_regs(mv, cs, tps, db);

      for (int n = 0; n < ItemsPerPhase; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)      req = REQ_TICK;
        else if (pick < 80) req = REQ_STEP;
        else if (pick < 95) req = REQ_PRESS;
        else                req = ReqSpare;
        dir = 1'($urandom_range(0, 1));
        now = $urandom;
        if (req == REQ_PRESS) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              wall_ms = wall_ms + $urandom_range(0, 2 * debounce + 20);
              now     = wall_ms;
            end
            5: now = last_press + {16'd0, debounce};
            6: now = last_press + {16'd0, debounce} + 32'd1;
            7: now = $urandom;
            8: now = last_press - $urandom_range(1, 50);
            default: now = wall_ms;
          endcase
        end
        send_beat(req, dir, now, 1'b0, '0, n == ItemsPerPhase - 1);
      end
    end

    while (display_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && display_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
